### sv/assert_macros.svh
// Shared assertion macros for the union-find engine checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle.
`define UFE_ASSERT_IMPLY(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

// Implication checked in the next cycle.
`define UFE_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

`endif

### sv/ufe_pkg.sv
// ----------------------------------------------------------------------------
// ufe_pkg
// Types and constants shared by the union-find engine modules.
// ----------------------------------------------------------------------------
`default_nettype none
package ufe_pkg;
    localparam int ELEM_W       = 10;
    localparam int SIZE_W       = 11;
    localparam int CMD_W        = 2;
    localparam int MAX_ELEM_DEF = 1024;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_UNION = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FIND  = 2'd2;

    typedef enum logic [2:0] {
        K_CLEAR,
        K_UNION,
        K_FIND,
        K_ERR,
        K_NOP
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [ELEM_W-1:0] a;
        logic [ELEM_W-1:0] b;
    } t_job;

    typedef struct packed {
        logic [ELEM_W-1:0] leader;
        logic [SIZE_W-1:0] group_size;
        logic              joined;
        logic              index_error;
    } t_result;

    typedef struct packed {
        logic [ELEM_W-1:0] parent;
        logic [SIZE_W-1:0] size;
    } t_entry;
endpackage
`default_nettype wire

### sv/ufe_fifo.sv
// ----------------------------------------------------------------------------
// ufe_fifo
// Small register queue that decouples a producer from a consumer.
// ----------------------------------------------------------------------------
`default_nettype none
module ufe_fifo import ufe_pkg::*; #(
    parameter type T = t_job
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_push,
    input  T     i_data,
    output logic o_full,
    input  wire  i_pop,
    output logic o_empty,
    output T     o_data
);
    localparam int PW = $clog2(QUEUE_DEPTH);

    T                 r_mem [QUEUE_DEPTH];
    logic [PW-1:0]    r_wp;
    logic [PW-1:0]    r_rp;
    logic [PW:0]      r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == (PW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + PW'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + PW'(1);
            end
            r_cnt <= r_cnt + (PW+1)'(do_push) - (PW+1)'(do_pop);
        end
    end
endmodule
`default_nettype wire

### sv/ufe_front.sv
// ----------------------------------------------------------------------------
// ufe_front
// Accepts commands, checks indices against the active limit and queues jobs.
// ----------------------------------------------------------------------------
`default_nettype none
module ufe_front import ufe_pkg::*; #(
    parameter int MAX_ELEMENTS = MAX_ELEM_DEF
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_hold,
    input  wire [SIZE_W-1:0]   i_active_count,
    input  wire                i_push,
    output logic               o_full,
    input  wire [CMD_W-1:0]    i_command,
    input  wire [ELEM_W-1:0]   i_elem_a,
    input  wire [ELEM_W-1:0]   i_elem_b,
    input  wire                i_job_pop,
    output logic               o_job_empty,
    output t_job               o_job
);
    logic a_ok;
    logic b_ok;
    logic q_full;
    t_job job;

    assign a_ok = (32'(i_elem_a) < 32'(i_active_count)) && (32'(i_elem_a) < 32'(MAX_ELEMENTS));
    assign b_ok = (32'(i_elem_b) < 32'(i_active_count)) && (32'(i_elem_b) < 32'(MAX_ELEMENTS));

    always_comb begin
        job.a = i_elem_a;
        job.b = i_elem_b;
        case (i_command)
            CMD_CLEAR: job.kind = K_CLEAR;
            CMD_UNION: job.kind = (a_ok && b_ok) ? K_UNION : K_ERR;
            CMD_FIND:  job.kind = a_ok ? K_FIND : K_ERR;
            default:   job.kind = K_NOP;
        endcase
    end

    assign o_full = q_full || i_hold;

    ufe_fifo #(.T(t_job)) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push && !i_hold),
        .i_data  (job),
        .o_full  (q_full),
        .i_pop   (i_job_pop),
        .o_empty (o_job_empty),
        .o_data  (o_job)
    );
endmodule
`default_nettype wire

### sv/ufe_back.sv
// ----------------------------------------------------------------------------
// ufe_back
// Executes jobs on the parent and size table held in a single-port memory.
// ----------------------------------------------------------------------------
`default_nettype none
module ufe_back import ufe_pkg::*; #(
    parameter int MAX_ELEMENTS = MAX_ELEM_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_job_empty,
    input  t_job       i_job,
    output logic       o_job_pop,
    output logic       o_init,
    input  wire        i_res_full,
    output logic       o_res_push,
    output t_result    o_res
);
    localparam int AW = $clog2(MAX_ELEMENTS);

    typedef enum logic [3:0] {
        S_IDLE, S_CLR, S_RD, S_RW, S_CRD, S_CWR, S_DONE, S_MRG1, S_MRG2, S_OUT
    } t_state;

    t_entry            r_mem [MAX_ELEMENTS];
    t_entry            r_rdata;
    t_state            r_state;
    logic              r_init;
    logic              r_union;
    logic              r_phase_b;
    logic [AW-1:0]     r_ctr;
    logic [ELEM_W-1:0] r_cur;
    logic [ELEM_W-1:0] r_elem;
    logic [ELEM_W-1:0] r_elem_b;
    logic [ELEM_W-1:0] r_root;
    logic [SIZE_W-1:0] r_rsize;
    logic [ELEM_W-1:0] r_x;
    logic [SIZE_W-1:0] r_xsize;
    logic [ELEM_W-1:0] r_big;
    logic [ELEM_W-1:0] r_small;
    logic [SIZE_W-1:0] r_ssize;
    logic [SIZE_W-1:0] r_sum;
    t_result           r_res;

    logic              mem_we;
    logic              mem_re;
    logic [AW-1:0]     mem_addr;
    t_entry            mem_wdata;

    always_comb begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_addr  = AW'(r_cur);
        mem_wdata = '{parent: r_root, size: r_rdata.size};
        case (r_state)
            S_CLR: begin
                mem_we    = 1'b1;
                mem_addr  = r_ctr;
                mem_wdata = '{parent: ELEM_W'(r_ctr), size: SIZE_W'(1)};
            end
            S_RD, S_CRD: begin
                mem_re = 1'b1;
            end
            S_CWR: begin
                mem_we = 1'b1;
            end
            S_MRG1: begin
                mem_we    = 1'b1;
                mem_addr  = AW'(r_big);
                mem_wdata = '{parent: r_big, size: r_sum};
            end
            S_MRG2: begin
                mem_we    = 1'b1;
                mem_addr  = AW'(r_small);
                mem_wdata = '{parent: r_big, size: r_ssize};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_addr];
        end
    end

    assign o_job_pop  = (r_state == S_IDLE) && !i_job_empty;
    assign o_init     = r_init;
    assign o_res_push = (r_state == S_OUT) && !i_res_full;
    assign o_res      = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_init  <= 1'b1;
            r_ctr   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (!i_job_empty) begin
                        r_res     <= '{leader: '0, group_size: '0, joined: 1'b0,
                                       index_error: (i_job.kind == K_ERR)};
                        r_cur     <= i_job.a;
                        r_elem    <= i_job.a;
                        r_elem_b  <= i_job.b;
                        r_phase_b <= 1'b0;
                        r_union   <= (i_job.kind == K_UNION);
                        r_ctr     <= '0;
                        case (i_job.kind)
                            K_CLEAR:         r_state <= S_CLR;
                            K_UNION, K_FIND: r_state <= S_RD;
                            default:         r_state <= S_OUT;
                        endcase
                    end
                end
                S_CLR: begin
                    r_ctr <= r_ctr + AW'(1);
                    if (r_ctr == AW'(MAX_ELEMENTS - 1)) begin
                        r_init  <= 1'b0;
                        r_state <= r_init ? S_IDLE : S_OUT;
                    end
                end
                S_RD: begin
                    r_state <= S_RW;
                end
                S_RW: begin
                    if (r_rdata.parent == r_cur) begin
                        r_root  <= r_cur;
                        r_rsize <= r_rdata.size;
                        r_cur   <= r_elem;
                        r_state <= (r_elem == r_cur) ? S_DONE : S_CRD;
                    end else begin
                        r_cur   <= r_rdata.parent;
                        r_state <= S_RD;
                    end
                end
                S_CRD: begin
                    r_state <= S_CWR;
                end
                S_CWR: begin
                    r_cur   <= r_rdata.parent;
                    r_state <= (r_rdata.parent == r_root) ? S_DONE : S_CRD;
                end
                S_DONE: begin
                    if (r_union && !r_phase_b) begin
                        r_x       <= r_root;
                        r_xsize   <= r_rsize;
                        r_phase_b <= 1'b1;
                        r_cur     <= r_elem_b;
                        r_elem    <= r_elem_b;
                        r_state   <= S_RD;
                    end else if (!r_union || r_x == r_root) begin
                        r_res   <= '{leader: (r_union ? r_x : r_root),
                                     group_size: (r_union ? r_xsize : r_rsize),
                                     joined: 1'b0, index_error: 1'b0};
                        r_state <= S_OUT;
                    end else begin
                        if (r_xsize < r_rsize) begin
                            r_big   <= r_root;
                            r_small <= r_x;
                            r_ssize <= r_xsize;
                        end else begin
                            r_big   <= r_x;
                            r_small <= r_root;
                            r_ssize <= r_rsize;
                        end
                        r_sum   <= r_xsize + r_rsize;
                        r_state <= S_MRG1;
                    end
                end
                S_MRG1: begin
                    r_state <= S_MRG2;
                end
                S_MRG2: begin
                    r_res   <= '{leader: r_big, group_size: r_sum, joined: 1'b1,
                                 index_error: 1'b0};
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!i_res_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

### sv/union_find_engine_unit.sv
// Find walks from the element to its root, then points each node on the path at the root.
// Union does both walks and, when the roots differ, links the smaller group to the larger.
// Clear rewrites every table entry; errors and unused commands go straight to a result word.
// Throughput is one item at a time, set by the walks through the single table memory port.
// Reset clears the table in one pass over MAX_ELEMENTS entries; full stays high meanwhile.
// ----------------------------------------------------------------------------
// union_find_engine_unit
// Disjoint-set engine with union by size and full path compression.
// ----------------------------------------------------------------------------
`default_nettype none
module union_find_engine_unit import ufe_pkg::*; #(
    parameter int MAX_ELEMENTS = MAX_ELEM_DEF
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_cfg_we,
    input  wire [SIZE_W-1:0]   i_cfg_wdata,
    input  wire                push,
    output logic               full,
    input  wire [CMD_W-1:0]    i_command,
    input  wire [ELEM_W-1:0]   i_elem_a,
    input  wire [ELEM_W-1:0]   i_elem_b,
    input  wire                pop,
    output logic               empty,
    output logic [ELEM_W-1:0]  o_leader,
    output logic [SIZE_W-1:0]  o_group_size,
    output logic               o_joined,
    output logic               o_index_error
);
    logic [SIZE_W-1:0] r_active_count;
    logic              job_empty;
    logic              job_pop;
    logic              init;
    logic              res_full;
    logic              res_push;
    t_job              job;
    t_result           res_in;
    t_result           res_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_count <= SIZE_W'(1024);
        end else if (i_cfg_we) begin
            r_active_count <= i_cfg_wdata;
        end
    end

    ufe_front #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_hold         (init),
        .i_active_count (r_active_count),
        .i_push         (push),
        .o_full         (full),
        .i_command      (i_command),
        .i_elem_a       (i_elem_a),
        .i_elem_b       (i_elem_b),
        .i_job_pop      (job_pop),
        .o_job_empty    (job_empty),
        .o_job          (job)
    );

    ufe_back #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (job_empty),
        .i_job       (job),
        .o_job_pop   (job_pop),
        .o_init      (init),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res_in)
    );

    ufe_fifo #(.T(t_result)) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (res_out)
    );

    assign o_leader      = res_out.leader;
    assign o_group_size  = res_out.group_size;
    assign o_joined      = res_out.joined;
    assign o_index_error = res_out.index_error;
endmodule
`default_nettype wire

### sv/ufe_checker.sv
// ----------------------------------------------------------------------------
// ufe_checker
// Port-level checks on the union-find engine results.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module ufe_checker import ufe_pkg::*; (
    input wire                i_clk,
    input wire                i_rst_n,
    input wire                pop,
    input wire                empty,
    input wire [ELEM_W-1:0]   o_leader,
    input wire [SIZE_W-1:0]   o_group_size,
    input wire                o_joined,
    input wire                o_index_error
);
    logic res_zero;
    logic join_ok;

    assign res_zero = (o_leader == '0) && (o_group_size == '0) && !o_joined;
    assign join_ok  = (o_group_size > SIZE_W'(1)) && !o_index_error;

    `UFE_ASSERT_IMPLY(a_err_zero, i_clk, i_rst_n, !empty && o_index_error, res_zero)
    `UFE_ASSERT_IMPLY(a_join_size, i_clk, i_rst_n, !empty && o_joined, join_ok)
    `UFE_ASSERT_NEXT(a_hold_res, i_clk, i_rst_n, !empty && !pop, !empty && $stable({o_leader, o_group_size}))
endmodule

bind union_find_engine_unit ufe_checker u_ufe_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .pop           (pop),
    .empty         (empty),
    .o_leader      (o_leader),
    .o_group_size  (o_group_size),
    .o_joined      (o_joined),
    .o_index_error (o_index_error)
);
`default_nettype wire

### sim/tb_union_find_engine_unit.sv
// ----------------------------------------------------------------------------
// tb_union_find_engine_unit
// The testbench drives directed and random clear, union, find and unused words
// into the engine and compares every result word with its directed expectation
// or its own disjoint-set predictor. The run sweeps the element limit and several idling and stall patterns.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_union_find_engine_unit;
    import ufe_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_ELEM = 1024;
    localparam int WATCHDOG_LIMIT = 60000;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [ELEM_W-1:0] a;
        logic [ELEM_W-1:0] b;
        bit                known;
        t_result           res;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [SIZE_W-1:0] i_cfg_wdata = '0;
    logic push = 1'b0;
    logic full;
    logic [CMD_W-1:0] i_command = '0;
    logic [ELEM_W-1:0] i_elem_a = '0;
    logic [ELEM_W-1:0] i_elem_b = '0;
    logic pop = 1'b0;
    logic empty;
    logic [ELEM_W-1:0] o_leader;
    logic [SIZE_W-1:0] o_group_size;
    logic o_joined;
    logic o_index_error;

    union_find_engine_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata), .push(push), .full(full),
        .i_command(i_command), .i_elem_a(i_elem_a), .i_elem_b(i_elem_b),
        .pop(pop), .empty(empty), .o_leader(o_leader),
        .o_group_size(o_group_size), .o_joined(o_joined),
        .o_index_error(o_index_error)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    logic [ELEM_W-1:0] forest_parent [N_ELEM];
    logic [SIZE_W-1:0] forest_size [N_ELEM];
    logic [SIZE_W-1:0] elem_limit;
    t_result pending_results [$];
    int mismatches = 0;
    int words_in = 0;
    int words_out = 0;
    int idle_sender = 0;
    int stall_receiver = 0;
    int watchdog = 0;
    bit timed_out = 0;

    function automatic void forest_clear();
        for (int i = 0; i < N_ELEM; i++) begin
            forest_parent[i] = i[ELEM_W-1:0];
            forest_size[i] = SIZE_W'(1);
        end
    endfunction

    function automatic logic [ELEM_W-1:0] forest_root(logic [ELEM_W-1:0] e);
        logic [ELEM_W-1:0] r;
        logic [ELEM_W-1:0] cur;
        logic [ELEM_W-1:0] nxt;
        int steps;
        r = e;
        steps = 0;
        while (forest_parent[r] != r && steps < N_ELEM) begin
            r = forest_parent[r];
            steps++;
        end
        cur = e;
        steps = 0;
        while (cur != r && steps < N_ELEM) begin
            nxt = forest_parent[cur];
            forest_parent[cur] = r;
            cur = nxt;
            steps++;
        end
        return r;
    endfunction

    function automatic t_result forest_apply(logic [CMD_W-1:0] cmd,
                                             logic [ELEM_W-1:0] a,
                                             logic [ELEM_W-1:0] b);
        t_result r;
        logic [ELEM_W-1:0] x;
        logic [ELEM_W-1:0] y;
        logic [ELEM_W-1:0] t;
        r = '0;
        if (cmd == CMD_CLEAR) begin
            forest_clear();
        end else if (cmd == CMD_UNION) begin
            if (a >= elem_limit || b >= elem_limit) begin
                r.index_error = 1'b1;
            end else begin
                x = forest_root(a);
                y = forest_root(b);
                if (x != y) begin
                    if (forest_size[x] < forest_size[y]) begin
                        t = x;
                        x = y;
                        y = t;
                    end
                    forest_size[x] = forest_size[x] + forest_size[y];
                    forest_parent[y] = x;
                    r.joined = 1'b1;
                end
                r.leader = x;
                r.group_size = forest_size[x];
            end
        end else if (cmd == CMD_FIND) begin
            if (a >= elem_limit) begin
                r.index_error = 1'b1;
            end else begin
                r.leader = forest_root(a);
                r.group_size = forest_size[r.leader];
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && pop && !empty) begin
            got = '{o_leader, o_group_size, o_joined, o_index_error};
            words_out++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result word %p", got);
                end
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result mismatch: expected %p, got %p", want, got);
                    end
                end
            end
        end
        if ((push && !full) || (pop && !empty)) begin
            watchdog = 0;
        end else if (i_rst_n) begin
            watchdog++;
        end
        if (watchdog >= WATCHDOG_LIMIT) begin
            $display("watchdog expired");
            $display("union_find_engine_unit regression: fail");
            $finish;
        end
        pop <= ($urandom_range(99) >= stall_receiver);
    end

    task automatic send_word(logic [CMD_W-1:0] cmd, logic [ELEM_W-1:0] a,
                             logic [ELEM_W-1:0] b, bit known, t_result res);
        t_result p;
        while ($urandom_range(99) < idle_sender) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_command <= cmd;
        i_elem_a <= a;
        i_elem_b <= b;
        do @(posedge i_clk); while (full);
        p = forest_apply(cmd, a, b);
        if (known && p !== res) begin
            $display("directed row %0d disagrees with predictor", words_in);
        end
        pending_results.push_back(known ? res : p);
        words_in++;
    endtask

    task automatic drain();
        push <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic set_limit(logic [SIZE_W-1:0] v);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        elem_limit = (v > N_ELEM) ? N_ELEM[SIZE_W-1:0] : v;
        @(posedge i_clk);
    endtask

    function automatic logic [ELEM_W-1:0] pick(int span);
        if ($urandom_range(9) == 0) begin
            return ELEM_W'($urandom);
        end
        return ELEM_W'($urandom_range(span - 1));
    endfunction

    task automatic random_phase(int count, int span, int idle_pct, int stall_pct);
        logic [CMD_W-1:0] c;
        int k;
        idle_sender = idle_pct;
        stall_receiver = stall_pct;
        for (int i = 0; i < count; i++) begin
            k = $urandom_range(99);
            c = (k < 3) ? CMD_CLEAR : (k < 5) ? CMD_UNUSED : (k < 55) ? CMD_UNION : CMD_FIND;
            send_word(c, pick(span), pick(span), 1'b0, '0);
        end
    endtask

    t_row directed [] = '{
        '{CMD_FIND,  10'd0,    10'd0,    1, '{10'd0, 11'd1, 1'b0, 1'b0}},
        '{CMD_FIND,  10'd1023, 10'd0,    1, '{10'd1023, 11'd1, 1'b0, 1'b0}},
        '{CMD_UNION, 10'd0,    10'd1,    1, '{10'd0, 11'd2, 1'b1, 1'b0}},
        '{CMD_UNION, 10'd2,    10'd0,    1, '{10'd0, 11'd3, 1'b1, 1'b0}},
        '{CMD_UNION, 10'd1,    10'd2,    1, '{10'd0, 11'd3, 1'b0, 1'b0}},
        '{CMD_UNION, 10'd1023, 10'd1022, 1, '{10'd1023, 11'd2, 1'b1, 1'b0}},
        '{CMD_UNION, 10'd1022, 10'd1,    0, '0},
        '{CMD_FIND,  10'd1023, 10'd0,    0, '0},
        '{CMD_UNUSED, 10'd5,   10'd6,    1, '0},
        '{CMD_UNION, 10'd5,    10'd5,    1, '{10'd5, 11'd1, 1'b0, 1'b0}},
        '{CMD_CLEAR, 10'd1023, 10'd1023, 1, '0},
        '{CMD_FIND,  10'd1022, 10'd0,    1, '{10'd1022, 11'd1, 1'b0, 1'b0}}
    };

    t_row limited [] = '{
        '{CMD_FIND,  10'd3,    10'd0,    1, '{10'd3, 11'd1, 1'b0, 1'b0}},
        '{CMD_FIND,  10'd4,    10'd0,    1, '{10'd0, 11'd0, 1'b0, 1'b1}},
        '{CMD_UNION, 10'd0,    10'd4,    1, '{10'd0, 11'd0, 1'b0, 1'b1}},
        '{CMD_UNION, 10'd1023, 10'd0,    1, '{10'd0, 11'd0, 1'b0, 1'b1}},
        '{CMD_UNION, 10'd3,    10'd2,    1, '{10'd3, 11'd2, 1'b1, 1'b0}},
        '{CMD_FIND,  10'd0,    10'd1023, 1, '{10'd0, 11'd1, 1'b0, 1'b0}}
    };

    initial begin
        forest_clear();
        elem_limit = N_ELEM[SIZE_W-1:0];
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (directed[i]) begin
            send_word(directed[i].cmd, directed[i].a, directed[i].b,
                      directed[i].known, directed[i].res);
        end
        set_limit(11'd4);
        foreach (limited[i]) begin
            send_word(limited[i].cmd, limited[i].a, limited[i].b,
                      limited[i].known, limited[i].res);
        end
        set_limit(11'd0);
        send_word(CMD_FIND, 10'd0, 10'd0, 1, '{10'd0, 11'd0, 1'b0, 1'b1});
        send_word(CMD_UNION, 10'd0, 10'd0, 1, '{10'd0, 11'd0, 1'b0, 1'b1});
        set_limit(11'd2047);
        random_phase(100, 16, 0, 0);
        set_limit(11'd1);
        random_phase(20, 2, 63, 0);
        set_limit(11'd40);
        random_phase(100, 48, 0, 63);
        drain();
        set_limit(11'd1024);
        random_phase(100, 1024, 23, 23);
        set_limit(11'd300);
        random_phase(80, 320, 0, 0);
        drain();
        $display("covered %0d words in, %0d results out, limits 0 to 2047",
                 words_in, words_out);
        if (mismatches == 0) begin
            $display("union_find_engine_unit regression: pass");
        end else begin
            $display("union_find_engine_unit regression: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire
